FILE: hdl/gd2a_pkg.sv
// shared types and constants of the 2x2 average downscaler
package gd2a_pkg;

    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 16;
    localparam int DATA_BITS   = 16;
    localparam int INDEX_BITS  = 1;

    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 13'd640;
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd480;

    localparam logic [INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        OP_STORE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic row_done;
        logic frame_done;
    } ctl_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] gray;
        logic                 row_done;
        logic                 frame_done;
    } result_t;

endpackage

FILE: hdl/gray_downscale_2x2_average.sv
// top level of the 2x2 average grayscale downscaler
//
// input channel: one grayscale pixel per request in raster order, pixel_value,
// handshake in_valid / in_stall. output channel: one half-size pixel per request,
// gray_out with row_done and frame_done marks, handshake out_valid / out_stall.
// frame size comes from the write port: index 0 frame_width, index 1 frame_height;
// they are to be written only while the block is idle; the block does not enforce it.
// throughput: one input pixel per cycle sustained; in_stall rises only when the
// request queue between the front and back ends is full.
// an output pixel becomes valid after the pixel that completes its 2x2 block is accepted
// and its request passes the request queue, the registered line store read and the result queue.
// odd last columns and rows are taken in and produce no output.
// reset clears the counters and queues and loads 640 x 480; the line store is not
// cleared, every entry is written on an even row before the odd row reads it.
// while out_stall is high up to four results are held; when they and the request
// queue fill, in_stall goes high until the receiver takes results again.
module gray_downscale_2x2_average #(
    parameter int MAX_COLUMNS = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pixel_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] gray_out,
    output logic        row_done,
    output logic        frame_done
);

    localparam int AW        = (MAX_COLUMNS / 2 > 1) ? $clog2(MAX_COLUMNS / 2) : 1;
    localparam int PW        = SAMPLE_BITS + 1;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_W     = $bits(gd2a_pkg::ctl_t) + AW + PW;
    localparam int CCW       = $clog2(CMD_DEPTH + 1);

    logic                 cmd_push;
    gd2a_pkg::ctl_t       f_ctl;
    logic [AW-1:0]        f_addr;
    logic [PW-1:0]        f_pair;
    logic                 cmd_pop;
    logic                 cmd_empty;
    logic                 cmd_full;
    logic [CCW-1:0]       cmd_count;
    logic [CMD_W-1:0]     q_bits;
    gd2a_pkg::ctl_t       b_ctl;
    logic [AW-1:0]        b_addr;
    logic [PW-1:0]        b_pair;
    logic                 queue_busy;
    gd2a_pkg::result_t    result;

    gd2a_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW),
        .PW          (PW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .queue_full  (queue_busy),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .cmd_push    (cmd_push),
        .cmd_ctl     (f_ctl),
        .cmd_addr    (f_addr),
        .cmd_pair    (f_pair)
    );

    assign queue_busy = cmd_full || (cmd_count == CCW'(CMD_DEPTH));

    gd2a_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data ({f_ctl, f_addr, f_pair}),
        .pop       (cmd_pop),
        .pop_data  (q_bits),
        .empty     (cmd_empty),
        .full      (cmd_full),
        .count     (cmd_count)
    );

    assign {b_ctl, b_addr, b_pair} = q_bits;

    gd2a_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW),
        .PW          (PW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!cmd_empty),
        .cmd_ctl    (b_ctl),
        .cmd_addr   (b_addr),
        .cmd_pair   (b_pair),
        .cmd_pop    (cmd_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    assign gray_out   = result.gray;
    assign row_done   = result.row_done;
    assign frame_done = result.frame_done;

endmodule

FILE: hdl/gd2a_ram.sv
// generic simple dual-port ram with registered read
module gd2a_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/gd2a_queue.sv
// small register fifo with occupancy count
module gd2a_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign count    = count_reg;

endmodule

FILE: hdl/gd2a_front.sv
// front end: frame registers, position counters, pair sums and request classification
module gd2a_front #(
    parameter int MAX_COLUMNS = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = (MAX_COLUMNS / 2 > 1) ? $clog2(MAX_COLUMNS / 2) : 1,
    parameter int PW          = SAMPLE_BITS + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [gd2a_pkg::INDEX_BITS-1:0] wr_index,
    input  logic [gd2a_pkg::HEIGHT_BITS-1:0] wr_data,
    input  logic                            in_valid,
    input  logic                            queue_full,
    output logic                            in_stall,
    input  logic [gd2a_pkg::DATA_BITS-1:0]  pixel_value,
    output logic                            cmd_push,
    output gd2a_pkg::ctl_t                  cmd_ctl,
    output logic [AW-1:0]                   cmd_addr,
    output logic [PW-1:0]                   cmd_pair
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int WB     = gd2a_pkg::WIDTH_BITS;
    localparam int HB     = gd2a_pkg::HEIGHT_BITS;
    localparam int CMP_W  = ((CW > WB) ? CW : WB) + 2;
    localparam int RCMP_W = HB + 2;
    localparam int CLAMP  = (MAX_COLUMNS > (1 << WB) - 1) ? (1 << WB) - 1 : MAX_COLUMNS;

    logic [WB-1:0]          width_reg;
    logic [HB-1:0]          height_reg;
    logic [CW-1:0]          col_reg;
    logic [CW-1:0]          col_next;
    logic [HB-1:0]          row_reg;
    logic [HB-1:0]          row_next;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] left_next;

    logic [WB-1:0]          w_eff;
    logic [HB-1:0]          h_eff;
    logic [CMP_W-1:0]       c_ext;
    logic [CMP_W-1:0]       w_ext;
    logic [RCMP_W-1:0]      r_ext;
    logic [RCMP_W-1:0]      h_ext;
    logic [SAMPLE_BITS-1:0] px;
    logic                   accept;
    logic                   pair_col;
    logic                   last_col;
    logic                   last_row;
    logic                   row_ok;
    logic                   rdone;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WB'(1);
        end
        else if (width_reg > WB'(CLAMP))
        begin
            w_eff = WB'(CLAMP);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HB'(1) : height_reg;
    end

    assign px       = pixel_value[SAMPLE_BITS-1:0];
    assign accept   = in_valid && !queue_full;
    assign in_stall = queue_full;

    assign c_ext    = CMP_W'(col_reg);
    assign w_ext    = CMP_W'(w_eff);
    assign r_ext    = RCMP_W'(row_reg);
    assign h_ext    = RCMP_W'(h_eff);

    assign pair_col = col_reg[0] && (c_ext + 1'b1 <= w_ext);
    assign last_col = (c_ext + 1'b1 >= w_ext);
    assign last_row = (r_ext + 1'b1 >= h_ext);
    assign row_ok   = (r_ext + 1'b1 <= h_ext);
    assign rdone    = (c_ext + CMP_W'(3) > w_ext);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        cmd_push  = 1'b0;
        cmd_ctl.op         = gd2a_pkg::OP_STORE;
        cmd_ctl.row_done   = rdone;
        cmd_ctl.frame_done = rdone && (r_ext + RCMP_W'(3) > h_ext);
        cmd_addr  = AW'(col_reg >> 1);
        cmd_pair  = PW'(left_reg) + PW'(px);
        if (accept)
        begin
            if (!col_reg[0])
            begin
                left_next = px;
            end
            else if (pair_col)
            begin
                if (!row_reg[0])
                begin
                    cmd_push = 1'b1;
                end
                else if (row_ok)
                begin
                    cmd_push   = 1'b1;
                    cmd_ctl.op = gd2a_pkg::OP_EMIT;
                end
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gd2a_pkg::RESET_WIDTH;
            height_reg <= gd2a_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    gd2a_pkg::REG_FRAME_WIDTH:  width_reg  <= wr_data[WB-1:0];
                    gd2a_pkg::REG_FRAME_HEIGHT: height_reg <= wr_data;
                    default: ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

endmodule

FILE: hdl/gd2a_back.sv
// back end: line store access, 2x2 average and result queue
module gd2a_back #(
    parameter int MAX_COLUMNS = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = (MAX_COLUMNS / 2 > 1) ? $clog2(MAX_COLUMNS / 2) : 1,
    parameter int PW          = SAMPLE_BITS + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  gd2a_pkg::ctl_t    cmd_ctl,
    input  logic [AW-1:0]     cmd_addr,
    input  logic [PW-1:0]     cmd_pair,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output gd2a_pkg::result_t out_result
);

    localparam int STORE_DEPTH = MAX_COLUMNS / 2;
    localparam int OUT_DEPTH   = 4;
    localparam int OCW         = $clog2(OUT_DEPTH + 1);
    localparam int SW          = SAMPLE_BITS + 2;
    localparam int RW          = $bits(gd2a_pkg::result_t);

    logic              pending_reg;
    logic              pending_next;
    logic [PW-1:0]     pair_reg;
    logic              rdone_reg;
    logic              fdone_reg;
    logic [PW-1:0]     rdata;
    logic [SW-1:0]     sum;
    logic [OCW-1:0]    out_count;
    logic              out_empty;
    logic              out_full;
    logic              out_pop;
    logic              room;
    logic              is_emit;
    logic              store_we;
    gd2a_pkg::result_t push_result;
    logic [RW-1:0]     pop_bits;

    assign is_emit  = (cmd_ctl.op == gd2a_pkg::OP_EMIT);
    assign room     = ((OCW + 1)'(out_count) + (OCW + 1)'(pending_reg)) < (OCW + 1)'(OUT_DEPTH);
    assign cmd_pop  = cmd_valid && (!is_emit || room);
    assign store_we = cmd_pop && !is_emit;
    assign pending_next = cmd_pop && is_emit;

    gd2a_ram #(
        .WIDTH (PW),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (cmd_addr),
        .wdata (cmd_pair),
        .raddr (cmd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pending_next)
        begin
            pair_reg  <= cmd_pair;
            rdone_reg <= cmd_ctl.row_done;
            fdone_reg <= cmd_ctl.frame_done;
        end
    end

    assign sum = SW'(rdata) + SW'(pair_reg);

    always_comb
    begin
        push_result.gray       = gd2a_pkg::DATA_BITS'(sum[SW-1:2]);
        push_result.row_done   = rdone_reg;
        push_result.frame_done = fdone_reg;
    end

    assign out_valid = !out_empty;
    assign out_pop   = out_valid && !out_stall;

    gd2a_queue #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pending_reg),
        .push_data (push_result),
        .pop       (out_pop),
        .pop_data  (pop_bits),
        .empty     (out_empty),
        .full      (out_full),
        .count     (out_count)
    );

    always_comb
    begin
        out_result = pop_bits;
        if (out_full && out_empty)
        begin
            out_result = '0;
        end
    end

endmodule
